/* hdl/dark_flat_pixel_calibration_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dark/flat pixel calibration unit
// Same-cycle and next-cycle implication checks on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef DARK_FLAT_PIXEL_CALIBRATION_UNIT_DEFINES_SVH
`define DARK_FLAT_PIXEL_CALIBRATION_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define DFPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define DFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dfpc_pkg.sv */
// ----------------------------------------------------------------------------
// dfpc_pkg
// Shared types and constants of the dark/flat pixel calibration unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfpc_pkg;

  localparam int CFG_AW = 3;   // two 32-bit registers at byte addresses 0 and 4
  localparam int CFG_DW = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_CHROMA_PLANE = 1'b0;
  localparam logic REG_DIV_SCALE    = 1'b1;

  localparam logic [15:0] DIV_SCALE_RST = 16'd255;

  localparam logic CMD_SUBTRACT = 1'b0;
  localparam logic CMD_DIVIDE   = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic       end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       end_of_frame_out;
  } out_word_t;

  typedef struct packed {
    logic        chroma_plane;
    logic [15:0] div_scale;
  } cfg_t;

  // word travelling down the pipeline
  typedef struct packed {
    logic        command;
    logic        chroma;
    logic        neg;     // chroma divide with pixel below centre
    logic        eof;
    logic [7:0]  b;       // divisor
    logic [9:0]  diff;    // subtract result, two's complement
    logic [23:0] mag;     // dividend magnitude
    logic [7:0]  rem;
    logic [7:0]  quo;
    logic        ovf;     // quotient above 255
  } pipe_t;

endpackage

/* hdl/dfpc_cfg.sv */
// ----------------------------------------------------------------------------
// dfpc_cfg
// APB register file: chroma_plane and div_scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfpc_pkg::CFG_AW-1:0]   paddr,
  input  logic [dfpc_pkg::CFG_DW-1:0]   pwdata,
  output logic [dfpc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output dfpc_pkg::cfg_t                cfg
);

  logic        chroma_r;
  logic [15:0] scale_r;
  logic        wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_r <= 1'b0;
      scale_r  <= dfpc_pkg::DIV_SCALE_RST;
    end else if (wr_en) begin
      case (paddr[2])
        dfpc_pkg::REG_CHROMA_PLANE: chroma_r <= pwdata[0];
        dfpc_pkg::REG_DIV_SCALE:    scale_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dfpc_pkg::REG_CHROMA_PLANE: prdata = {31'd0, chroma_r};
      dfpc_pkg::REG_DIV_SCALE:    prdata = {16'd0, scale_r};
      default:                    prdata = '0;
    endcase
  end

  assign cfg.chroma_plane = chroma_r;
  assign cfg.div_scale    = scale_r;

endmodule

/* hdl/dfpc_mul.sv */
// ----------------------------------------------------------------------------
// dfpc_mul
// Entry stage: subtract path and the 8x16 scale product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfpc_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  dfpc_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  dfpc_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dfpc_pkg::pipe_t    out_data
);

  logic            v_r;
  dfpc_pkg::pipe_t d_r;
  dfpc_pkg::pipe_t d_nxt;
  logic [7:0]      abs_c;
  logic [7:0]      mul_op;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    // distance from the chroma centre, at most 128
    abs_c  = in_data.pixel_a[7] ? {1'b0, in_data.pixel_a[6:0]}
                                : 8'd128 - in_data.pixel_a;
    mul_op = cfg.chroma_plane ? abs_c : in_data.pixel_a;

    d_nxt         = '0;
    d_nxt.command = in_data.command;
    d_nxt.chroma  = cfg.chroma_plane;
    d_nxt.neg     = cfg.chroma_plane & ~in_data.pixel_a[7];
    d_nxt.eof     = in_data.end_of_frame;
    d_nxt.b       = in_data.pixel_b;
    d_nxt.diff    = {2'b00, in_data.pixel_a} - {2'b00, in_data.pixel_b}
                  + (cfg.chroma_plane ? 10'd128 : 10'd0);
    d_nxt.mag     = {16'd0, mul_op} * {8'd0, cfg.div_scale};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

/* hdl/dfpc_div.sv */
// ----------------------------------------------------------------------------
// dfpc_div
// Two-stage restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dark_flat_pixel_calibration_unit_defines.svh"

module dfpc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dfpc_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dfpc_pkg::pipe_t out_data
);

  logic            v2_r, v3_r;
  logic            rdy2, rdy3;
  dfpc_pkg::pipe_t d2_r, d3_r;
  dfpc_pkg::pipe_t d2_nxt, d3_nxt;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                          input logic [7:0] dvs);
    logic [8:0] trial;
    logic [8:0] sub;
    begin
      trial = {rem, nb};
      sub   = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
        return {1'b1, sub[7:0]};
      end
      return {1'b0, trial[7:0]};
    end
  endfunction

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = rdy2;

  always_comb begin
    logic [8:0] st;
    d2_nxt     = in_data;
    // quotient fits 8 bits only if the top 16 bits stay below the divisor
    d2_nxt.ovf = in_data.mag[23:8] >= {8'd0, in_data.b};
    d2_nxt.rem = in_data.mag[15:8];
    d2_nxt.quo = '0;
    for (int i = 0; i < 4; i++) begin
      st         = div_step(d2_nxt.rem, in_data.mag[7-i], in_data.b);
      d2_nxt.rem = st[7:0];
      d2_nxt.quo = {d2_nxt.quo[6:0], st[8]};
    end
  end

  always_comb begin
    logic [8:0] st;
    d3_nxt = d2_r;
    for (int i = 0; i < 4; i++) begin
      st         = div_step(d3_nxt.rem, d2_r.mag[3-i], d2_r.b);
      d3_nxt.rem = st[7:0];
      d3_nxt.quo = {d3_nxt.quo[6:0], st[8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= in_valid;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) d2_r <= d2_nxt;
    if (rdy3 && v2_r)     d3_r <= d3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = d3_r;

  `DFPC_ASSERT_NOW(a_rem_below_div, v2_r && !d2_r.ovf && d2_r.b != 8'd0,
                   d2_r.rem < d2_r.b, "partial remainder not below divisor")
  `DFPC_ASSERT_NOW(a_quo_exact, v3_r && !d3_r.ovf && d3_r.b != 8'd0,
                   d3_r.mag == ({16'd0, d3_r.quo} * {16'd0, d3_r.b}
                                + {16'd0, d3_r.rem}),
                   "quotient and remainder do not rebuild the dividend")

endmodule

/* hdl/dfpc_out.sv */
// ----------------------------------------------------------------------------
// dfpc_out
// Final stage: plane offset, saturation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dark_flat_pixel_calibration_unit_defines.svh"

module dfpc_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dfpc_pkg::pipe_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dfpc_pkg::out_word_t out_data
);

  logic                v_r;
  dfpc_pkg::out_word_t d_r;
  dfpc_pkg::out_word_t d_nxt;
  logic [8:0]          qf;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    qf = in_data.ovf ? 9'd256 : {1'b0, in_data.quo};
    d_nxt.end_of_frame_out = in_data.eof;
    if (in_data.command == dfpc_pkg::CMD_SUBTRACT) begin
      if (in_data.diff[9])      d_nxt.pixel_out = 8'd0;
      else if (in_data.diff[8]) d_nxt.pixel_out = 8'd255;
      else                      d_nxt.pixel_out = in_data.diff[7:0];
    end else if (in_data.b == 8'd0) begin
      d_nxt.pixel_out = 8'd255;
    end else if (!in_data.chroma) begin
      d_nxt.pixel_out = in_data.ovf ? 8'd255 : in_data.quo;
    end else if (in_data.neg) begin
      d_nxt.pixel_out = (qf > 9'd128) ? 8'd0 : 8'(9'd128 - qf);
    end else begin
      d_nxt.pixel_out = (qf > 9'd127) ? 8'd255 : 8'(9'd128 + qf);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

  `DFPC_ASSERT_NEXT(a_zero_div_full, in_valid && in_ready
                    && in_data.command == dfpc_pkg::CMD_DIVIDE && in_data.b == 8'd0,
                    out_data.pixel_out == 8'd255, "zero divisor not forced to full scale")

endmodule

/* hdl/dark_flat_pixel_calibration_unit.sv */
// ----------------------------------------------------------------------------
// dark_flat_pixel_calibration_unit
// Per-pixel dark-frame subtract and flat-field divide for 8-bit planes.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one word per pixel holding
//    the command, raw pixel, reference pixel and frame-end flag.
//  - Output channel (out_valid/out_ready/out_data): one calibrated pixel
//    word per input word, in order, frame-end flag copied across.
//  - APB port: chroma_plane at 0x0, div_scale at 0x4; write only while idle.
//  - Four register stages: entry/multiply, two divider stages of four
//    quotient bits each, then saturation into the output register.
//    An accepted word is registered in each of these stages in turn.
//  - Throughput is one word per clock while out_ready holds; the 8-bit quotient is split over the
//    two divider stages, which sets the depth.
//  - A stalled receiver holds the output register; each stage refills only
//    when empty or draining, so bubbles collapse and nothing is dropped.
//  - Synchronous reset empties every stage and restores chroma_plane = 0,
//    div_scale = 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dark_flat_pixel_calibration_unit_defines.svh"

module dark_flat_pixel_calibration_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dfpc_pkg::in_word_t            in_data,
  // calibrated output
  output logic                          out_valid,
  input  logic                          out_ready,
  output dfpc_pkg::out_word_t           out_data,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfpc_pkg::CFG_AW-1:0]   paddr,
  input  logic [dfpc_pkg::CFG_DW-1:0]   pwdata,
  output logic [dfpc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  dfpc_pkg::cfg_t  cfg;

  // stage hand-offs
  logic            mul_valid, mul_ready;
  dfpc_pkg::pipe_t mul_data;
  logic            div_valid, div_ready;
  dfpc_pkg::pipe_t div_data;

  dfpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // difference and scale product
  dfpc_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  // magnitude quotient, overflow flagged above 255
  dfpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // centre offset, saturation, output register
  dfpc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a draining output must open the whole pipe to new words
  `DFPC_ASSERT_NOW(a_ready_through, out_ready, in_ready,
                   "input blocked while output drains")

endmodule
